// File: rtl/diff_drive_slew_limited_mixer_top_assert.svh
// ----------------------------------------------------------------------------
// diff drive mixer assertion macros
// property wrappers for the checker file ddsm_check
// ----------------------------------------------------------------------------
`ifndef DIFF_DRIVE_SLEW_LIMITED_MIXER_TOP_ASSERT_SVH
`define DIFF_DRIVE_SLEW_LIMITED_MIXER_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define DDSM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define DDSM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/ddsm_pkg.sv
// ----------------------------------------------------------------------------
// ddsm_pkg
// shared types and constants of the diff drive mixer
// ----------------------------------------------------------------------------
package ddsm_pkg;

    localparam int DataW = 32;
    localparam int UnsW  = 31;
    localparam int IdxW  = 3;

    localparam logic [IdxW-1:0] REG_INV_RADIUS     = 3'd0;
    localparam logic [IdxW-1:0] REG_ICR_OFFSET     = 3'd1;
    localparam logic [IdxW-1:0] REG_THROTTLE_SCALE = 3'd2;
    localparam logic [IdxW-1:0] REG_STEER_SCALE    = 3'd3;
    localparam logic [IdxW-1:0] REG_THROTTLE_LIMIT = 3'd4;
    localparam logic [IdxW-1:0] REG_STEER_LIMIT    = 3'd5;

    typedef enum logic [2:0] {
        MUL_SPEED_INV,
        MUL_ROT_ICR,
        MUL_RS_INV,
        MUL_TR_SCALE,
        MUL_SR_SCALE
    } mul_sel_t;

    typedef enum logic [2:0] {
        RND_TRATE,
        RND_RS,
        RND_SRATE,
        RND_TCMD,
        RND_SCMD
    } rnd_dst_t;

    typedef struct packed {
        logic     capture;
        mul_sel_t mul_sel;
        logic     rnd_en;
        rnd_dst_t rnd_dst;
        logic     slew_en;
        logic     out_load;
    } ddsm_cmd_t;

endpackage

// File: rtl/ddsm_ctrl.sv
// ----------------------------------------------------------------------------
// ddsm_ctrl
// sequencer for the shared multiplier, limiter and output handshake
// ----------------------------------------------------------------------------
module ddsm_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    output logic               out_valid,
    input  logic               out_stall,
    output ddsm_pkg::ddsm_cmd_t cmd
);
    import ddsm_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_M1,
        ST_M2,
        ST_M3,
        ST_RS,
        ST_M4,
        ST_SLEW,
        ST_M5,
        ST_M6,
        ST_M7,
        ST_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        cmd.mul_sel    = MUL_SPEED_INV;
        cmd.rnd_dst    = RND_TRATE;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_M1;
                end
            end
            ST_M1:
            begin
                cmd.mul_sel = MUL_SPEED_INV;
                state_next  = ST_M2;
            end
            ST_M2:
            begin
                cmd.rnd_en  = 1'b1;
                cmd.rnd_dst = RND_TRATE;
                cmd.mul_sel = MUL_ROT_ICR;
                state_next  = ST_M3;
            end
            ST_M3:
            begin
                cmd.rnd_en  = 1'b1;
                cmd.rnd_dst = RND_RS;
                state_next  = ST_RS;
            end
            ST_RS:
            begin
                cmd.mul_sel = MUL_RS_INV;
                state_next  = ST_M4;
            end
            ST_M4:
            begin
                cmd.rnd_en  = 1'b1;
                cmd.rnd_dst = RND_SRATE;
                state_next  = ST_SLEW;
            end
            ST_SLEW:
            begin
                cmd.slew_en = 1'b1;
                state_next  = ST_M5;
            end
            ST_M5:
            begin
                cmd.mul_sel = MUL_TR_SCALE;
                state_next  = ST_M6;
            end
            ST_M6:
            begin
                cmd.rnd_en  = 1'b1;
                cmd.rnd_dst = RND_TCMD;
                cmd.mul_sel = MUL_SR_SCALE;
                state_next  = ST_M7;
            end
            ST_M7:
            begin
                cmd.rnd_en  = 1'b1;
                cmd.rnd_dst = RND_SCMD;
                state_next  = ST_OUT;
            end
            ST_OUT:
            begin
                // old result leaves or slot is empty
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// File: rtl/ddsm_dp.sv
// ----------------------------------------------------------------------------
// ddsm_dp
// config registers, shared multiplier, rounding, slew limiters, result regs
// ----------------------------------------------------------------------------
module ddsm_dp (
    input  logic                               clk,
    input  logic                               rst_n,
    input  ddsm_pkg::ddsm_cmd_t                cmd,
    input  logic                               cfg_wr_en,
    input  logic [ddsm_pkg::IdxW-1:0]          cfg_index,
    input  logic [ddsm_pkg::DataW-1:0]         cfg_data,
    input  logic signed [ddsm_pkg::DataW-1:0]  speed,
    input  logic signed [ddsm_pkg::DataW-1:0]  rotation,
    output logic signed [ddsm_pkg::DataW-1:0]  throttle_cmd,
    output logic signed [ddsm_pkg::DataW-1:0]  steering_cmd,
    output logic                               throttle_limited,
    output logic                               steering_limited
);
    import ddsm_pkg::*;

    typedef struct packed {
        logic [DataW-1:0] rate;
        logic             clip;
    } slew_res_t;

    function automatic logic [DataW-1:0] rnd_sat(input logic signed [2*DataW-1:0] p);
        logic signed [2*DataW:0]       sum;
        logic signed [2*DataW-16:0]    sh;
        logic [DataW-1:0]              res;
        sum = {p[2*DataW-1], p} + (2*DataW+1)'(32768);
        sh  = sum[2*DataW:16];
        if (&sh[2*DataW-16:DataW-1] || ~|sh[2*DataW-16:DataW-1])
            res = sh[DataW-1:0];
        else if (sh[2*DataW-16])
            res = {1'b1, {(DataW-1){1'b0}}};
        else
            res = {1'b0, {(DataW-1){1'b1}}};
        return res;
    endfunction

    function automatic slew_res_t slew(input logic signed [DataW-1:0] nxt,
                                       input logic signed [DataW-1:0] prv,
                                       input logic [UnsW-1:0] lim);
        logic signed [DataW:0] d;
        logic signed [DataW:0] nx;
        logic signed [DataW:0] pv;
        logic [DataW:0]        an;
        logic [DataW:0]        ap;
        logic [DataW:0]        ad;
        logic [DataW:0]        lx;
        logic [DataW:0]        stepped;
        slew_res_t             r;
        nx = {nxt[DataW-1], nxt};
        pv = {prv[DataW-1], prv};
        lx = {2'b00, lim};
        d  = nx - pv;
        an = nx[DataW] ? (DataW+1)'(-nx) : (DataW+1)'(nx);
        ap = pv[DataW] ? (DataW+1)'(-pv) : (DataW+1)'(pv);
        ad = d[DataW] ? (DataW+1)'(-d) : (DataW+1)'(d);
        stepped = d[DataW] ? (DataW+1)'(pv - $signed(lx)) : (DataW+1)'(pv + $signed(lx));
        r.clip = (an > ap) && (ad > lx);
        r.rate = r.clip ? stepped[DataW-1:0] : nxt;
        return r;
    endfunction

    logic [UnsW-1:0]         inv_radius_reg;
    logic signed [DataW-1:0] icr_offset_reg;
    logic signed [DataW-1:0] throttle_scale_reg;
    logic signed [DataW-1:0] steer_scale_reg;
    logic [UnsW-1:0]         throttle_limit_reg;
    logic [UnsW-1:0]         steer_limit_reg;

    logic signed [DataW-1:0]   speed_reg;
    logic signed [DataW-1:0]   rotation_reg;
    logic signed [2*DataW-1:0] prod_reg;
    logic signed [DataW-1:0]   trate_reg;
    logic signed [DataW-1:0]   rs_reg;
    logic signed [DataW-1:0]   srate_reg;
    logic signed [DataW-1:0]   prev_t_reg;
    logic signed [DataW-1:0]   prev_s_reg;
    logic                      tclip_reg;
    logic                      sclip_reg;
    logic signed [DataW-1:0]   tcmd_reg;
    logic signed [DataW-1:0]   scmd_reg;
    logic signed [DataW-1:0]   out_t_reg;
    logic signed [DataW-1:0]   out_s_reg;
    logic                      out_tl_reg;
    logic                      out_sl_reg;

    logic signed [DataW-1:0] op_a;
    logic signed [DataW-1:0] op_b;
    logic [DataW-1:0]        rnd_val;
    slew_res_t               t_slew;
    slew_res_t               s_slew;

    always_comb
    begin
        case (cmd.mul_sel)
            MUL_SPEED_INV:
            begin
                op_a = speed_reg;
                op_b = {1'b0, inv_radius_reg};
            end
            MUL_ROT_ICR:
            begin
                op_a = rotation_reg;
                op_b = icr_offset_reg;
            end
            MUL_RS_INV:
            begin
                op_a = rs_reg;
                op_b = {1'b0, inv_radius_reg};
            end
            MUL_TR_SCALE:
            begin
                op_a = prev_t_reg;
                op_b = throttle_scale_reg;
            end
            MUL_SR_SCALE:
            begin
                op_a = prev_s_reg;
                op_b = steer_scale_reg;
            end
            default:
            begin
                op_a = speed_reg;
                op_b = {1'b0, inv_radius_reg};
            end
        endcase
    end

    assign rnd_val = rnd_sat(prod_reg);
    assign t_slew  = slew(trate_reg, prev_t_reg, throttle_limit_reg);
    assign s_slew  = slew(srate_reg, prev_s_reg, steer_limit_reg);

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_radius_reg     <= UnsW'(65536);
            icr_offset_reg     <= '0;
            throttle_scale_reg <= DataW'(65536);
            steer_scale_reg    <= DataW'(65536);
            throttle_limit_reg <= '1;
            steer_limit_reg    <= '1;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_INV_RADIUS:     inv_radius_reg     <= cfg_data[UnsW-1:0];
                REG_ICR_OFFSET:     icr_offset_reg     <= cfg_data;
                REG_THROTTLE_SCALE: throttle_scale_reg <= cfg_data;
                REG_STEER_SCALE:    steer_scale_reg    <= cfg_data;
                REG_THROTTLE_LIMIT: throttle_limit_reg <= cfg_data[UnsW-1:0];
                REG_STEER_LIMIT:    steer_limit_reg    <= cfg_data[UnsW-1:0];
                default:            ;
            endcase
        end
    end

    // previous rates
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_t_reg <= '0;
            prev_s_reg <= '0;
        end
        else if (cmd.slew_en)
        begin
            prev_t_reg <= t_slew.rate;
            prev_s_reg <= s_slew.rate;
        end
    end

    // working and result registers
    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
        if (cmd.capture)
        begin
            speed_reg    <= speed;
            rotation_reg <= rotation;
        end
        if (cmd.rnd_en)
        begin
            case (cmd.rnd_dst)
                RND_TRATE: trate_reg <= rnd_val;
                RND_RS:    rs_reg    <= rnd_val;
                RND_SRATE: srate_reg <= rnd_val;
                RND_TCMD:  tcmd_reg  <= rnd_val;
                RND_SCMD:  scmd_reg  <= rnd_val;
                default:   ;
            endcase
        end
        if (cmd.slew_en)
        begin
            tclip_reg <= t_slew.clip;
            sclip_reg <= s_slew.clip;
        end
        if (cmd.out_load)
        begin
            out_t_reg  <= tcmd_reg;
            out_s_reg  <= scmd_reg;
            out_tl_reg <= tclip_reg;
            out_sl_reg <= sclip_reg;
        end
    end

    assign throttle_cmd     = out_t_reg;
    assign steering_cmd     = out_s_reg;
    assign throttle_limited = out_tl_reg;
    assign steering_limited = out_sl_reg;

endmodule

// File: rtl/diff_drive_slew_limited_mixer_top.sv
// ----------------------------------------------------------------------------
// diff_drive_slew_limited_mixer_top
// differential drive mixer with per-step slew limiting and Q16.16 scaling
// ----------------------------------------------------------------------------
// One item is worked at a time. After an input transfer the result appears
// in the output register, and the next input can be taken in the same cycle
// as the result appears. The order of work is set by the single shared 32x32
// multiplier, which runs five products per item, each rounded and saturated in
// the cycle after it; the rounding overlaps the next product except where that
// product needs the rounded value, which costs a step of its own for the
// steering rate. The two slew limiters and the load of the output register
// each take a step of their own. A finished result waits in the output
// register while the next item is in work; a stall there only holds the block
// at its last step.
module diff_drive_slew_limited_mixer_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [ddsm_pkg::IdxW-1:0]          cfg_index,
    input  logic [ddsm_pkg::DataW-1:0]         cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic signed [ddsm_pkg::DataW-1:0]  speed,
    input  logic signed [ddsm_pkg::DataW-1:0]  rotation,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [ddsm_pkg::DataW-1:0]  throttle_cmd,
    output logic signed [ddsm_pkg::DataW-1:0]  steering_cmd,
    output logic                               throttle_limited,
    output logic                               steering_limited
);
    import ddsm_pkg::*;

    ddsm_cmd_t cmd;

    ddsm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    ddsm_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .speed            (speed),
        .rotation         (rotation),
        .throttle_cmd     (throttle_cmd),
        .steering_cmd     (steering_cmd),
        .throttle_limited (throttle_limited),
        .steering_limited (steering_limited)
    );

endmodule

// File: rtl/ddsm_check.sv
// ----------------------------------------------------------------------------
// ddsm_check
// port-level checks of the diff drive mixer, bound to the top level
// ----------------------------------------------------------------------------
`include "diff_drive_slew_limited_mixer_top_assert.svh"

module ddsm_check (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_stall,
    input logic                              out_valid,
    input logic                              out_stall,
    input logic signed [ddsm_pkg::DataW-1:0] throttle_cmd,
    input logic signed [ddsm_pkg::DataW-1:0] steering_cmd
);

    // busy right after an input transfer
    `DDSM_ASSERT_NXT(a_busy_after_in, in_valid && !in_stall, in_stall, "idle after input transfer")

    // a new result shows up only as the block goes idle
    `DDSM_ASSERT_IMP(a_idle_on_result, $rose(out_valid), !in_stall, "result while busy")

    // held result
    `DDSM_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")

    `DDSM_ASSERT_NXT(a_out_stable, out_valid && out_stall,
        $stable(throttle_cmd) && $stable(steering_cmd), "stalled result changed")

endmodule

bind diff_drive_slew_limited_mixer_top ddsm_check u_ddsm_check (.*);
